### hw/rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared operation codes and the control bundle that goes to the storage cells.
// ---------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

### hw/rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. It compares its priority with the incoming one,
// then keeps its entry, takes the new entry, or takes its neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                      clk,
  input  spq_pkg::cell_ctrl_t       ctrl,
  input  logic                      head_slot,
  input  logic                      slot_valid,
  input  logic [7:0]                new_data,
  input  logic [PRIORITY_WIDTH-1:0] new_prio,
  input  logic                      prev_le,
  input  logic [7:0]                prev_data,
  input  logic [PRIORITY_WIDTH-1:0] prev_prio,
  input  logic [7:0]                next_data,
  input  logic [PRIORITY_WIDTH-1:0] next_prio,
  output logic                      le,
  output logic [7:0]                data,
  output logic [PRIORITY_WIDTH-1:0] prio
);
  import spq_pkg::*;

  logic place_here;

  // insert point is at or before this slot; the head only yields to a strictly
  // lower priority
  assign place_here = head_slot ? (prio > new_prio) : (prio >= new_prio);
  assign le         = !slot_valid || place_here;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (prev_le) begin
        data <= prev_data;
        prio <= prev_prio;
      end else if (le) begin
        data <= new_data;
        prio <= new_prio;
      end
    end else if (ctrl.pop) begin
      data <= next_data;
      prio <= next_prio;
    end
  end

endmodule

### hw/rtl/sorted_priority_queue.sv
// The result beat of an accepted input beat is offered in the next cycle. One
// push or pop is taken per cycle unless an offered result is stalled; every
// cell of the row updates in the same cycle, so the next beat is taken while
// the previous result is offered. Reset clears the entry count and the output
// valid; slot contents are not cleared and are never read before being written.
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of cells; lowest value first.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic [7:0]                           item_data,
  input  logic [PRIORITY_WIDTH-1:0]            item_priority,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           head_data,
  output logic [PRIORITY_WIDTH-1:0]            head_priority,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     entry_count,
  output logic                                 queue_empty,
  output logic                                 op_error
);
  import spq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]           count;
  logic [CntW-1:0]           count_next;
  logic                      err;
  logic                      err_next;
  logic                      out_valid_next;
  logic                      in_acc;
  logic                      is_full;
  logic                      is_empty;
  cell_ctrl_t                ctrl;

  logic                      cell_le   [QUEUE_DEPTH];
  logic [7:0]                cell_data [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_prio [QUEUE_DEPTH];

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign is_full  = (count == CntW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    ctrl.push      = in_acc && (operation == OP_PUSH) && !is_full;
    ctrl.pop       = in_acc && (operation == OP_POP) && !is_empty;
    count_next     = count;
    err_next       = err;
    out_valid_next = out_valid && out_stall;
    if (ctrl.push) begin
      count_next = count + CntW'(1);
    end else if (ctrl.pop) begin
      count_next = count - CntW'(1);
    end
    if (in_acc) begin
      out_valid_next = 1'b1;
      err_next       = (operation == OP_PUSH) ? is_full : is_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      err       <= err_next;
      out_valid <= out_valid_next;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                      prev_le;
    logic [7:0]                prev_data;
    logic [PRIORITY_WIDTH-1:0] prev_prio;
    logic [7:0]                next_data;
    logic [PRIORITY_WIDTH-1:0] next_prio;

    if (i == 0) begin : g_first
      assign prev_le   = 1'b0;
      assign prev_data = item_data;
      assign prev_prio = item_priority;
    end else begin : g_mid
      assign prev_le   = cell_le[i-1];
      assign prev_data = cell_data[i-1];
      assign prev_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
      assign next_prio = cell_prio[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
      assign next_prio = cell_prio[i+1];
    end

    spq_cell #(
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .head_slot (i == 0),
      .slot_valid(count > CntW'(i)),
      .new_data  (item_data),
      .new_prio  (item_priority),
      .prev_le   (prev_le),
      .prev_data (prev_data),
      .prev_prio (prev_prio),
      .next_data (next_data),
      .next_prio (next_prio),
      .le        (cell_le[i]),
      .data      (cell_data[i]),
      .prio      (cell_prio[i])
    );
  end

  assign head_data     = is_empty ? 8'd0 : cell_data[0];
  assign head_priority = is_empty ? '0 : cell_prio[0];
  assign entry_count   = count;
  assign queue_empty   = is_empty;
  assign op_error      = err;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    in_acc && (operation == OP_POP) && is_empty |=> op_error && (count == '0))
    else $error("pop on empty not flagged or changed count");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> (count == $past(count) + CntW'(1)) && !op_error)
    else $error("push did not grow the queue");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CntW'(2) |-> cell_prio[0] <= cell_prio[1])
    else $error("head out of order");
`endif

endmodule
